FILE: rtl/core/urr_pkg.sv
// Shared types and constants for the UART receive ring with error flush.
// Depends on nothing; used by uart_rx_ring_with_error_flush.
`default_nettype none

package urr_pkg;

  // Default ring depth; one slot always stays empty.
  localparam int unsigned RING_DEPTH_DEF = 512;

  // Reset value of the loss report interval in milliseconds.
  localparam logic [15:0] REPORT_INTERVAL_RST = 16'd500;

  // Input actions.
  localparam logic ACT_LINE = 1'b0;
  localparam logic ACT_TAKE = 1'b1;

  // Result status codes.
  localparam logic [2:0] STS_BYTE_OUT = 3'd0;
  localparam logic [2:0] STS_EMPTY    = 3'd1;
  localparam logic [2:0] STS_FLUSHED  = 3'd2;
  localparam logic [2:0] STS_STORED   = 3'd3;
  localparam logic [2:0] STS_OVERFLOW = 3'd4;
  localparam logic [2:0] STS_NO_BYTE  = 3'd5;

  // One input word.
  typedef struct packed {
    logic        action;
    logic [3:0]  line_errors;
    logic        has_byte;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
  } urr_in_t;

  // One result word.
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  data_byte;
    logic        report_now;
    logic [31:0] error_count;
    logic [31:0] overflow_count;
    logic [3:0]  errors_seen;
    logic [31:0] byte_count;
  } urr_out_t;

endpackage

`default_nettype wire

FILE: rtl/core/uart_rx_ring_with_error_flush.sv
// Top level of the UART receive ring with error flush and loss reporting.
// Depends on urr_pkg for the word types, status codes and defaults.
//
//   channel  handshake             payload      direction
//   input    start, busy           in_data      in
//   result   out_valid (strobe)    out_data     out
//   config   cfg_valid, cfg_ready  cfg_data     in
//
// Each word has an accept cycle, which reads the ring memory at the read
// pointer, and an execute cycle, which uses the registered read data,
// updates the pointers and counters and writes the ring. busy is high in the
// execute cycle, and the result strobe follows in the next cycle, when a new
// word may already be accepted. The single-port ring read sets this.
// Reset is synchronous and clears all control state and counters; the ring
// contents are not cleared. The result side cannot stall.
`default_nettype none

module uart_rx_ring_with_error_flush #(
  parameter int unsigned RING_DEPTH = urr_pkg::RING_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire urr_pkg::urr_in_t in_data,
  output logic                  out_valid,
  output urr_pkg::urr_out_t     out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [15:0]      cfg_data
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t            state_r, state_nxt;
  urr_pkg::urr_in_t  item_r;
  logic [7:0]        rd_data_r;
  logic [7:0]        ring_mem [RING_DEPTH];

  logic [PTR_W-1:0]  read_ptr_r, read_ptr_nxt;
  logic [PTR_W-1:0]  write_ptr_r, write_ptr_nxt;
  logic              bad_flag_r, bad_flag_nxt;
  logic [31:0]       error_events_r, error_events_nxt;
  logic [31:0]       overflow_events_r, overflow_events_nxt;
  logic [31:0]       bytes_received_r, bytes_received_nxt;
  logic [3:0]        error_bits_r, error_bits_nxt;
  logic [31:0]       last_report_r, last_report_nxt;
  logic              report_pending_r, report_pending_nxt;
  logic [15:0]       interval_r;

  logic              out_valid_r, out_valid_nxt;
  urr_pkg::urr_out_t out_data_r, out_data_nxt;

  logic              accept;
  logic              mem_we;
  logic [PTR_W-1:0]  write_inc;
  logic [PTR_W-1:0]  read_inc;
  logic [31:0]       elapsed;
  logic [2:0]        status;
  logic [7:0]        data_byte;
  logic              report;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // Pointer increments wrap at the ring depth.
  assign write_inc = (write_ptr_r == PTR_LAST) ? '0 : write_ptr_r + 1'b1;
  assign read_inc  = (read_ptr_r == PTR_LAST) ? '0 : read_ptr_r + 1'b1;
  assign elapsed   = item_r.now_ms - last_report_r;

  // Execute one word against the current state.
  always_comb begin
    state_nxt           = state_r;
    read_ptr_nxt        = read_ptr_r;
    write_ptr_nxt       = write_ptr_r;
    bad_flag_nxt        = bad_flag_r;
    error_events_nxt    = error_events_r;
    overflow_events_nxt = overflow_events_r;
    bytes_received_nxt  = bytes_received_r;
    error_bits_nxt      = error_bits_r;
    last_report_nxt     = last_report_r;
    report_pending_nxt  = report_pending_r;
    mem_we              = 1'b0;
    status              = urr_pkg::STS_NO_BYTE;
    data_byte           = 8'd0;
    report              = 1'b0;
    out_valid_nxt       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        if (item_r.action == urr_pkg::ACT_LINE) begin
          if (item_r.line_errors != 4'd0) begin
            bad_flag_nxt     = 1'b1;
            error_events_nxt = error_events_r + 32'd1;
            error_bits_nxt   = error_bits_r | item_r.line_errors;
          end
          if (item_r.has_byte) begin
            bytes_received_nxt = bytes_received_r + 32'd1;
            if (write_inc == read_ptr_r) begin
              bad_flag_nxt        = 1'b1;
              overflow_events_nxt = overflow_events_r + 32'd1;
              status              = urr_pkg::STS_OVERFLOW;
            end else begin
              mem_we        = 1'b1;
              write_ptr_nxt = write_inc;
              status        = urr_pkg::STS_STORED;
            end
          end
        end else begin
          // Rate-limited loss report comes before the flush.
          if (report_pending_r && (elapsed >= {16'd0, interval_r})) begin
            report_pending_nxt = 1'b0;
            last_report_nxt    = item_r.now_ms;
            report             = 1'b1;
          end
          if (bad_flag_r) begin
            read_ptr_nxt       = write_ptr_r;
            bad_flag_nxt       = 1'b0;
            report_pending_nxt = 1'b1;
            status             = urr_pkg::STS_FLUSHED;
          end else if (read_ptr_r == write_ptr_r) begin
            status = urr_pkg::STS_EMPTY;
          end else begin
            data_byte    = rd_data_r;
            read_ptr_nxt = read_inc;
            status       = urr_pkg::STS_BYTE_OUT;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_data_nxt                = out_data_r;
    if (state_r == ST_EXEC) begin
      out_data_nxt.status         = status;
      out_data_nxt.data_byte      = data_byte;
      out_data_nxt.report_now     = report;
      out_data_nxt.error_count    = error_events_nxt;
      out_data_nxt.overflow_count = overflow_events_nxt;
      out_data_nxt.errors_seen    = error_bits_nxt;
      out_data_nxt.byte_count     = bytes_received_nxt;
    end
  end

  // Ring memory: read at accept, written in the execute cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= ring_mem[read_ptr_r];
    end
    if (mem_we) begin
      ring_mem[write_ptr_r] <= item_r.rx_byte;
    end
  end

  // Input word capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
  end

  // State, counters and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      read_ptr_r        <= '0;
      write_ptr_r       <= '0;
      bad_flag_r        <= 1'b0;
      error_events_r    <= 32'd0;
      overflow_events_r <= 32'd0;
      bytes_received_r  <= 32'd0;
      error_bits_r      <= 4'd0;
      last_report_r     <= 32'd0;
      report_pending_r  <= 1'b0;
      interval_r        <= urr_pkg::REPORT_INTERVAL_RST;
      out_valid_r       <= 1'b0;
    end else begin
      state_r           <= state_nxt;
      read_ptr_r        <= read_ptr_nxt;
      write_ptr_r       <= write_ptr_nxt;
      bad_flag_r        <= bad_flag_nxt;
      error_events_r    <= error_events_nxt;
      overflow_events_r <= overflow_events_nxt;
      bytes_received_r  <= bytes_received_nxt;
      error_bits_r      <= error_bits_nxt;
      last_report_r     <= last_report_nxt;
      report_pending_r  <= report_pending_nxt;
      out_valid_r       <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        interval_r <= cfg_data;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // An accepted word makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // Every execute cycle ends in exactly one result strobe.
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("execute cycle without result");

  // A loss report only comes with a take status.
  a_report_take: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.report_now) |->
      (out_data.status == urr_pkg::STS_BYTE_OUT ||
       out_data.status == urr_pkg::STS_EMPTY ||
       out_data.status == urr_pkg::STS_FLUSHED))
    else $error("loss report on a line event");

  // After a flush the ring reads as empty and the bad flag is clear.
  a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == urr_pkg::STS_FLUSHED) |->
      (read_ptr_r == write_ptr_r && !bad_flag_r))
    else $error("flush left data or bad flag");
`endif

endmodule

`default_nettype wire
